// ===== hdl/adccal_pkg.sv =====
package adccal_pkg;

    // Field widths of the sample path and the channel number.
    localparam int DATA_W = 12;
    localparam int CH_W   = 4;
    localparam int NUM_W  = 2 * DATA_W;

    // Width used to compare a channel number against the channel count.
    localparam int CH_EXT_W = 7;

    // Full-scale output code and default channel count.
    localparam logic [DATA_W-1:0] FULL_SCALE = 12'd4095;
    localparam int CHANNELS_DEF = 16;

    // Configuration register reset values.
    localparam logic [15:0]       ANALOG_MASK_RST = 16'hFFFF;
    localparam logic [DATA_W-1:0] MIN_SPAN_RST    = 12'd100;

    // Configuration register indexes (register i sits at byte address 4*i).
    localparam logic REG_ANALOG_MASK = 1'b0;
    localparam logic REG_MIN_SPAN    = 1'b1;

    // Stream payload widths.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // Item actions carried in tuser.
    typedef enum logic [1:0] {
        ACT_CONVERT = 2'd0,
        ACT_START   = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/adc_channel_calibration_scaler.sv =====
// Per-channel ADC range calibration and rescaling. Each item carries an action in tuser
// (convert, start calibration, stop calibration) and the channel and raw sample in tdata.
// Each item gives exactly one result item. An item passes through the modify, scale and
// done states, and a sample inside the calibrated range also through the divide state, the
// bit-serial restoring divider that forms the quotient one bit per cycle; commands,
// clamped or pass-through samples need no division. The block works on one item at a time:
// the range memory is read at acceptance, modified and written back before the next item is
// taken. A finished result waits in the output register, and the block takes the next item
// while it waits; a result that is finished while the previous one still waits holds the
// block until the sink takes it. Configuration registers (analog_mask at 0x0, min_span at
// 0x4) are written over the APB port; the user must write them only while the block is
// idle, which the block itself does not enforce. The range memory needs no clearing pass:
// a valid bit per channel makes an unwritten channel read as the full range.
module adc_channel_calibration_scaler #(
    parameter int CHANNELS = adccal_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: channel [3:0], sample [15:4]
    input  logic [adccal_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: action [1:0]
    input  logic [1:0]                          s_axis_tuser,

    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: scaled_value [11:0], stored_min [23:12], stored_max [35:24],
    // calibrating [36], calibrating_channel [40:37], cal_rejected [41], zero [47:42]
    output logic [adccal_pkg::OUT_DATA_W-1:0]   m_axis_tdata,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int DW     = adccal_pkg::DATA_W;
    localparam int CW     = adccal_pkg::CH_W;
    localparam int NW     = adccal_pkg::NUM_W;
    localparam int EW     = adccal_pkg::CH_EXT_W;
    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0] DIV_LAST = 4'(DW - 1);

    // Configuration registers.
    logic [15:0]   analog_mask_reg;
    logic [DW-1:0] min_span_reg;

    // Sequencer and capture state.
    adccal_pkg::state_t state_reg, state_next;
    logic          cap_active_reg, cap_active_next;
    logic [CW-1:0] cap_ch_reg, cap_ch_next;

    // Item registers.
    adccal_pkg::action_t act_reg;
    logic [CW-1:0]       ch_reg;
    logic [DW-1:0]       smp_reg;
    logic                ok_reg;
    logic [ADDR_W-1:0]   addr_reg;

    // Range memory, one {max, min} word per channel, and its valid bits.
    logic [2*DW-1:0]     range_mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [2*DW-1:0]     rd_data_reg;
    logic                rd_valid_reg;

    // Updated range and divider registers.
    logic [DW-1:0] lo_reg, hi_reg;
    logic          rej_reg;
    logic [DW-1:0] rem_reg, quo_reg, div_reg;
    logic [3:0]    cnt_reg;

    // Output register.
    logic                                out_valid_reg;
    logic [adccal_pkg::OUT_DATA_W-1:0]   out_data_reg;

    // Combinational helpers.
    logic              accept;
    logic              load_out;
    logic              cfg_wr;
    logic [CW-1:0]     in_ch;
    logic [EW-1:0]     rd_ch_ext;
    logic              rd_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [DW-1:0]     cur_lo, cur_hi;
    logic [DW-1:0]     new_lo, new_hi;
    logic              wr_en;
    logic              rej_next;
    logic              need_div;
    logic              range_ok;
    logic [DW-1:0]     scaled_next;
    logic [DW-1:0]     diff;
    logic [NW-1:0]     num;
    logic [DW:0]       trial;
    logic [DW:0]       shifted;

    // Configuration port: writes decode on paddr[2], reads return the register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            adccal_pkg::REG_ANALOG_MASK: prdata = {16'd0, analog_mask_reg};
            default:                     prdata = {{(32 - DW){1'b0}}, min_span_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            analog_mask_reg <= adccal_pkg::ANALOG_MASK_RST;
            min_span_reg    <= adccal_pkg::MIN_SPAN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                adccal_pkg::REG_ANALOG_MASK: analog_mask_reg <= pwdata[15:0];
                default:                     min_span_reg    <= pwdata[DW-1:0];
            endcase
        end
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = (state_reg == adccal_pkg::ST_IDLE);
        load_out      = (state_reg == adccal_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            adccal_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = adccal_pkg::ST_MODIFY;
            end
            adccal_pkg::ST_MODIFY:
                state_next = adccal_pkg::ST_SCALE;
            adccal_pkg::ST_SCALE:
            begin
                if (need_div)
                    state_next = adccal_pkg::ST_DIV;
                else
                    state_next = adccal_pkg::ST_DONE;
            end
            adccal_pkg::ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = adccal_pkg::ST_DONE;
            end
            adccal_pkg::ST_DONE:
            begin
                if (load_out)
                    state_next = adccal_pkg::ST_IDLE;
            end
            default:
                state_next = adccal_pkg::ST_IDLE;
        endcase
    end

    // Memory read address: a stop reports the capture channel, all else the item channel.
    always_comb
    begin
        in_ch = s_axis_tdata[CW-1:0];
        if (adccal_pkg::action_t'(s_axis_tuser) == adccal_pkg::ACT_STOP)
            rd_ch_ext = {{(EW - CW){1'b0}}, cap_ch_reg};
        else
            rd_ch_ext = {{(EW - CW){1'b0}}, in_ch};
        rd_ok   = rd_ch_ext < EW'(CHANNELS);
        rd_addr = rd_ch_ext[ADDR_W-1:0];
    end

    // Capture the item and read its channel's range.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= adccal_pkg::action_t'(s_axis_tuser);
            ch_reg       <= in_ch;
            smp_reg      <= s_axis_tdata[CW +: DW];
            ok_reg       <= rd_ok;
            addr_reg     <= rd_addr;
            rd_data_reg  <= rd_ok ? range_mem[rd_addr] : '0;
            rd_valid_reg <= rd_ok ? valid_reg[rd_addr] : 1'b0;
        end
    end

    // Read-modify: an unwritten or out-of-range channel holds the full range.
    always_comb
    begin
        if (ok_reg && rd_valid_reg)
        begin
            cur_lo = rd_data_reg[DW-1:0];
            cur_hi = rd_data_reg[2*DW-1:DW];
        end
        else
        begin
            cur_lo = '0;
            cur_hi = adccal_pkg::FULL_SCALE;
        end

        new_lo          = cur_lo;
        new_hi          = cur_hi;
        wr_en           = 1'b0;
        rej_next        = 1'b0;
        cap_active_next = cap_active_reg;
        cap_ch_next     = cap_ch_reg;

        case (act_reg)
            adccal_pkg::ACT_CONVERT:
            begin
                // Widen the captured range with a sample on the capture channel.
                if (cap_active_reg && (ch_reg == cap_ch_reg) && ok_reg)
                begin
                    if (smp_reg < cur_lo)
                        new_lo = smp_reg;
                    if (smp_reg > cur_hi)
                        new_hi = smp_reg;
                    wr_en = 1'b1;
                end
            end
            adccal_pkg::ACT_START:
            begin
                // Open an empty range on an analog channel.
                if (ok_reg && analog_mask_reg[ch_reg])
                begin
                    cap_active_next = 1'b1;
                    cap_ch_next     = ch_reg;
                    new_lo          = adccal_pkg::FULL_SCALE;
                    new_hi          = '0;
                    wr_en           = 1'b1;
                end
            end
            adccal_pkg::ACT_STOP:
            begin
                // Reject an empty or too narrow range and restore the full range.
                if (cap_active_reg && ok_reg)
                begin
                    if ((cur_lo >= cur_hi) || ((cur_hi - cur_lo) < min_span_reg))
                    begin
                        new_lo   = '0;
                        new_hi   = adccal_pkg::FULL_SCALE;
                        wr_en    = 1'b1;
                        rej_next = 1'b1;
                    end
                    cap_active_next = 1'b0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Write back the range and keep it for scaling and reporting.
    always_ff @(posedge clk)
    begin
        if (state_reg == adccal_pkg::ST_MODIFY)
        begin
            lo_reg  <= new_lo;
            hi_reg  <= new_hi;
            rej_reg <= rej_next;
            if (wr_en)
                range_mem[addr_reg] <= {new_hi, new_lo};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= adccal_pkg::ST_IDLE;
            cap_active_reg <= 1'b0;
            cap_ch_reg     <= '0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == adccal_pkg::ST_MODIFY)
            begin
                cap_active_reg <= cap_active_next;
                cap_ch_reg     <= cap_ch_next;
                if (wr_en)
                    valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Scaling decision: clamp, pass through, or divide.
    always_comb
    begin
        range_ok    = lo_reg < hi_reg;
        diff        = smp_reg - lo_reg;
        num         = NW'(diff) * NW'(adccal_pkg::FULL_SCALE);
        need_div    = 1'b0;
        scaled_next = '0;
        if (act_reg == adccal_pkg::ACT_CONVERT)
        begin
            if (!range_ok)
                scaled_next = smp_reg;
            else if (smp_reg <= lo_reg)
                scaled_next = '0;
            else if (smp_reg >= hi_reg)
                scaled_next = adccal_pkg::FULL_SCALE;
            else
                need_div = 1'b1;
        end
    end

    // Restoring divider step: one quotient bit per cycle.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        trial   = shifted - {1'b0, div_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == adccal_pkg::ST_SCALE)
        begin
            cnt_reg <= '0;
            div_reg <= hi_reg - lo_reg;
            if (need_div)
            begin
                rem_reg <= num[NW-1:DW];
                quo_reg <= num[DW-1:0];
            end
            else
            begin
                rem_reg <= '0;
                quo_reg <= scaled_next;
            end
        end
        else if (state_reg == adccal_pkg::ST_DIV)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (!trial[DW])
            begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    // Output register: holds a finished result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= {6'd0, rej_reg, cap_ch_reg, cap_active_reg, hi_reg, lo_reg, quo_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Only one item is in flight: an accepted item closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // The divider only runs on a nonempty range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == adccal_pkg::ST_DIV) |-> (div_reg != '0))
        else $error("divider running with a zero divisor");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwritten before it was taken");

    // A rejection only comes from a stop.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == adccal_pkg::ST_SCALE) && (act_reg != adccal_pkg::ACT_STOP)) |-> !rej_reg)
        else $error("calibration rejected on an item that is not a stop");
`endif

endmodule
